[rtl/ndf_pkg.sv]
// Shared constants, codes and types for the nonlinear diffusion 3x3 filter.
// No dependencies; used by the top level, the port checker and the testbench.
package ndf_pkg;

  localparam int DEF_MAX_ROW_LENGTH = 1024;
  localparam int DEF_TABLE_DEPTH    = 256;
  localparam int DEF_PIXEL_BITS     = 16;

  localparam int MAX_ROW_COUNT = 4096;
  localparam int ROW_BITS      = $clog2(MAX_ROW_COUNT + 2);

  localparam int FRAC_BITS   = 8;
  localparam int INDEX_BITS  = 8;
  localparam int WEIGHT_BITS = 17;
  localparam int WSUM_BITS   = 20;
  localparam int CW_BITS     = 21;
  localparam int ONE_Q16     = 65536;
  localparam int HALF_Q16    = 32768;
  localparam int ROUND_SHIFT = 16;

  localparam int LEN_BITS       = 11;
  localparam int CNT_BITS       = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int RESET_LEN      = 256;
  localparam int RESET_ROWS     = 256;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam int NB_TAPS = 8;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } edge_flags_t;

endpackage

[rtl/nonlinear_diffusion_3x3_filter_top.sv]
// Nonlinear diffusion 3x3 filter: line buffer, window, weight lookup and MAC pipeline.
// Depends on ndf_pkg and ndf_wtab_ram.
//
// Usage:
//   s_* carries items: s_tuser is the opcode (load table word, pixel, drain),
//   s_tdata holds pixel_value, table_index and table_weight. m_* carries
//   results: m_tdata is the smoothed pixel, m_tlast marks the final pixel of
//   the frame, m_tuser flags a clamped sum. cfg_* writes row_length (index 0)
//   and row_count (index 1); a write restarts the frame.
//   One item per cycle is taken while s_tready is high; a result passes the
//   stages line buffer read, window, weight table read, products, centre
//   product with first adder level, second adder level, accumulate, rounding.
//   Results lag their pixel by one row plus one pixel; drain items flush the
//   last row plus one pixel, or the one row of a one-row frame. For a one-row
//   frame s_tready drops for one cycle after the last pixel: a window step is inserted.
//   Reset (synchronous) empties the pipeline, zeroes the window and counters
//   and sets both registers to 256; table and line buffer stay unwritten.
//   A stalled receiver holds m_*; each stage fills up in turn before
//   s_tready falls, so nothing is lost or repeated.
module nonlinear_diffusion_3x3_filter_top #(
  parameter int MAX_ROW_LENGTH = ndf_pkg::DEF_MAX_ROW_LENGTH,
  parameter int TABLE_DEPTH    = ndf_pkg::DEF_TABLE_DEPTH,
  parameter int PIXEL_BITS     = ndf_pkg::DEF_PIXEL_BITS,
  localparam int IN_W  = ((PIXEL_BITS + ndf_pkg::INDEX_BITS + ndf_pkg::WEIGHT_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // pixel_value, table_index, table_weight (from bit 0 up)
  input  logic [IN_W-1:0]                    s_tdata,
  // opcode
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // smoothed_value
  output logic [OUT_W-1:0]                   m_tdata,
  output logic                               m_tlast,
  // saturated
  output logic [0:0]                         m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ndf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ndf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import ndf_pkg::*;

  localparam int PB  = PIXEL_BITS;
  localparam int CW  = $clog2(MAX_ROW_LENGTH);
  localparam int LW  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int EW  = (LW > LEN_BITS) ? LW : LEN_BITS;
  localparam int PW  = $clog2(MAX_ROW_LENGTH + 2);
  localparam int RW  = ROW_BITS;
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int IXW = (PB > TAW + 1) ? PB : TAW + 1;
  localparam int LXW = (INDEX_BITS > TAW + 1) ? INDEX_BITS : TAW + 1;
  localparam int PRW = PB + WEIGHT_BITS;
  localparam int CPW = CW_BITS + PB + 1;
  localparam int AW  = PB + 23;
  localparam int HW  = AW - ROUND_SHIFT;

  typedef struct packed {
    logic                   step;
    logic                   wr;
    logic                   emit;
    logic                   load;
    edge_flags_t            fl;
    logic [CW-1:0]          addr;
    logic [PB-1:0]          pix;
    logic [INDEX_BITS-1:0]  tidx;
    logic [WEIGHT_BITS-1:0] twt;
  } s1_t;

  // ---------------- configuration ----------------
  logic [LEN_BITS-1:0] row_length;
  logic [CNT_BITS-1:0] row_count;
  logic [LW-1:0]       w;
  logic [RW-1:0]       h;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (row_length == '0) w = LW'(1);
    else if (EW'(row_length) > EW'(MAX_ROW_LENGTH)) w = LW'(MAX_ROW_LENGTH);
    else w = LW'(row_length);
    if (row_count == '0) h = RW'(1);
    else if (row_count > CNT_BITS'(MAX_ROW_COUNT)) h = RW'(MAX_ROW_COUNT);
    else h = RW'(row_count);
  end

  // ---------------- stage enables ----------------
  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7, en_o;

  assign en_o = !m_tvalid || m_tready;
  assign en7  = !v7 || en_o;
  assign en6  = !v6 || en7;
  assign en5  = !v5 || en6;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;

  // ---------------- front end: position counters ----------------
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] pend;
  logic          pad;

  logic          take, restart_px, cz;
  logic          st_step, st_wr, st_emit, st_load;
  logic [CW-1:0] pc;
  logic [RW-1:0] pr;
  logic [LW-1:0] c1;
  edge_flags_t   fl;

  assign s_tready   = en1 && !pad;
  assign take       = s_tvalid && s_tready;
  assign restart_px = (pend != '0) || (row >= h);

  always_comb begin
    st_step = 1'b0;
    st_wr   = 1'b0;
    st_emit = 1'b0;
    st_load = 1'b0;
    pc      = col;
    pr      = row;
    if (pad && en1) begin
      st_step = 1'b1;
    end else if (take) begin
      unique case (s_tuser)
        OP_LOAD: st_load = 1'b1;
        OP_PIXEL: begin
          st_step = 1'b1;
          st_wr   = 1'b1;
          if (restart_px) begin
            pc = '0;
            pr = '0;
          end
        end
        OP_DRAIN: begin
          if (pend != '0) begin
            st_step = 1'b1;
            st_emit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    cz = (pc == '0);
    // a pixel yields the result one row plus one pixel behind it
    if (st_wr) st_emit = (pr >= RW'(2)) || ((pr == RW'(1)) && !cz);
    c1        = LW'(pc) + LW'(1);
    fl.right  = cz;
    fl.left   = cz ? (w == LW'(1)) : (pc == CW'(1));
    fl.top    = cz ? (pr == RW'(2)) : (pr == RW'(1));
    fl.bottom = cz ? (pr == h + RW'(1)) : (pr == h);
    fl.last   = fl.bottom && fl.right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_BITS'(RESET_LEN);
      row_count  <= CNT_BITS'(RESET_ROWS);
      col        <= '0;
      row        <= '0;
      pend       <= '0;
      pad        <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_LENGTH) row_length <= cfg_data[LEN_BITS-1:0];
      else row_count <= cfg_data[CNT_BITS-1:0];
      col  <= '0;
      row  <= '0;
      pend <= '0;
      pad  <= 1'b0;
    end else if (st_step) begin
      if (c1 == w) begin
        col <= '0;
        row <= pr + RW'(1);
      end else begin
        col <= CW'(c1);
        row <= pr;
      end
      if (st_wr) begin
        if ((c1 == w) && (pr + RW'(1) == h)) begin
          pend <= (h == RW'(1)) ? PW'(w) : PW'(w) + PW'(1);
          pad  <= (h == RW'(1));
        end else begin
          pend <= '0;
        end
      end else if (st_emit) begin
        pend <= pend - PW'(1);
      end else begin
        pad <= 1'b0;
      end
    end
  end

  // ---------------- stage 1: line buffer read ----------------
  s1_t s1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en1) v1 <= st_step || st_load;
    if (en1) begin
      s1.step <= st_step;
      s1.wr   <= st_wr;
      s1.emit <= st_emit;
      s1.load <= st_load;
      s1.fl   <= fl;
      s1.addr <= pc;
      s1.pix  <= s_tdata[PB-1:0];
      s1.tidx <= s_tdata[PB+INDEX_BITS-1:PB];
      s1.twt  <= s_tdata[PB+INDEX_BITS+WEIGHT_BITS-1:PB+INDEX_BITS];
    end
  end

  // entry: upper half two rows back, lower half one row back
  logic [2*PB-1:0] lbuf [MAX_ROW_LENGTH];
  logic [2*PB-1:0] lb_rd, lb_fwd, lb_cur, lb_wdata;
  logic            lb_hit, lb_we;

  assign lb_cur   = lb_hit ? lb_fwd : lb_rd;
  assign lb_wdata = {lb_cur[PB-1:0], s1.pix};
  assign lb_we    = v1 && s1.wr && en2;

  always_ff @(posedge clk) begin
    if (lb_we) lbuf[s1.addr] <= lb_wdata;
    if (en1) begin
      lb_rd  <= lbuf[pc];
      lb_fwd <= lb_wdata;
    end
  end

  // forward a write that lands on the edge the next read is taken
  always_ff @(posedge clk) begin
    if (rst) lb_hit <= 1'b0;
    else if (en1) lb_hit <= lb_we && (s1.addr == pc);
  end

  // ---------------- stage 2: window ----------------
  logic [PB-1:0] p1 [3];
  logic [PB-1:0] p2 [3];
  logic [PB-1:0] nc [3];
  logic [PB-1:0] lc [3];
  logic [PB-1:0] rc [3];
  logic [PB-1:0] taps_next [9];

  assign nc[0] = lb_cur[2*PB-1:PB];
  assign nc[1] = lb_cur[PB-1:0];
  assign nc[2] = s1.pix;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lc[i] = s1.fl.left  ? p1[i] : p2[i];
      rc[i] = s1.fl.right ? p1[i] : nc[i];
    end
    taps_next[0] = s1.fl.top    ? lc[1] : lc[0];
    taps_next[1] = s1.fl.top    ? p1[1] : p1[0];
    taps_next[2] = s1.fl.top    ? rc[1] : rc[0];
    taps_next[3] = lc[1];
    taps_next[4] = p1[1];
    taps_next[5] = rc[1];
    taps_next[6] = s1.fl.bottom ? lc[1] : lc[2];
    taps_next[7] = s1.fl.bottom ? p1[1] : p1[2];
    taps_next[8] = s1.fl.bottom ? rc[1] : rc[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= '0;
        p2[i] <= '0;
      end
    end else if (v1 && s1.step && en2) begin
      for (int i = 0; i < 3; i++) begin
        p2[i] <= p1[i];
        p1[i] <= nc[i];
      end
    end
  end

  logic                   s2_emit, s2_load, s2_last;
  logic [INDEX_BITS-1:0]  s2_tidx;
  logic [WEIGHT_BITS-1:0] s2_twt;
  logic [PB-1:0]          s2_taps [9];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en2) v2 <= v1;
    if (en2) begin
      s2_emit <= s1.emit;
      s2_load <= s1.load;
      s2_last <= s1.fl.last;
      s2_tidx <= s1.tidx;
      s2_twt  <= s1.twt;
      for (int k = 0; k < 9; k++) s2_taps[k] <= taps_next[k];
    end
  end

  // ---------------- stage 3: weight table read ----------------
  logic [TAW-1:0]         raddr [NB_TAPS];
  logic [WEIGHT_BITS-1:0] wt [NB_TAPS];
  logic [PB-1:0]          dif [NB_TAPS];
  logic [IXW-1:0]         ix [NB_TAPS];
  logic                   tw_we;

  always_comb begin
    for (int n = 0; n < NB_TAPS; n++) begin
      automatic int k = (n < 4) ? n : n + 1;
      dif[n] = (s2_taps[k] > s2_taps[4]) ? s2_taps[k] - s2_taps[4]
                                          : s2_taps[4] - s2_taps[k];
      ix[n]  = IXW'(dif[n] >> FRAC_BITS);
      // differences past the table use its last entry
      raddr[n] = (ix[n] > IXW'(TABLE_DEPTH - 1)) ? TAW'(TABLE_DEPTH - 1) : TAW'(ix[n]);
    end
  end

  assign tw_we = v2 && s2_load && en3 && (LXW'(s2_tidx) < LXW'(TABLE_DEPTH));

  for (genvar g = 0; g < NB_TAPS / 2; g++) begin : g_wtab
    ndf_wtab_ram #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(WEIGHT_BITS)
    ) u_wtab (
      .clk    (clk),
      .we     (tw_we),
      .waddr  (TAW'(s2_tidx)),
      .wdata  (s2_twt),
      .en     (en3),
      .raddr_a(raddr[2*g]),
      .raddr_b(raddr[2*g+1]),
      .rdata_a(wt[2*g]),
      .rdata_b(wt[2*g+1])
    );
  end

  logic [PB-1:0] s3_px [NB_TAPS];
  logic [PB-1:0] s3_ctr;
  logic          s3_last;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en3) v3 <= v2 && s2_emit;
    if (en3) begin
      for (int n = 0; n < NB_TAPS; n++) s3_px[n] <= s2_taps[(n < 4) ? n : n + 1];
      s3_ctr  <= s2_taps[4];
      s3_last <= s2_last;
    end
  end

  // ---------------- stage 4: neighbour products, centre weight ----------------
  logic [PRW-1:0]            s4_prod [NB_TAPS];
  logic signed [CW_BITS-1:0] s4_cw;
  logic [PB-1:0]             s4_ctr;
  logic                      s4_last;
  logic [WSUM_BITS-1:0]      wsum;

  always_comb begin
    wsum = '0;
    for (int n = 0; n < NB_TAPS; n++) wsum = wsum + WSUM_BITS'(wt[n]);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en4) v4 <= v3;
    if (en4) begin
      for (int n = 0; n < NB_TAPS; n++) s4_prod[n] <= PRW'(wt[n]) * PRW'(s3_px[n]);
      s4_cw   <= $signed(CW_BITS'(ONE_Q16)) - $signed({1'b0, wsum});
      s4_ctr  <= s3_ctr;
      s4_last <= s3_last;
    end
  end

  // ---------------- stage 5: centre product, first adder level ----------------
  logic signed [CPW-1:0] s5_cprod;
  logic [PRW:0]          s5_sum [4];
  logic                  s5_last;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en5) v5 <= v4;
    if (en5) begin
      s5_cprod <= s4_cw * $signed({1'b0, s4_ctr});
      for (int i = 0; i < 4; i++)
        s5_sum[i] <= (PRW+1)'(s4_prod[2*i]) + (PRW+1)'(s4_prod[2*i+1]);
      s5_last <= s4_last;
    end
  end

  // ---------------- stage 6: second adder level ----------------
  logic signed [CPW-1:0] s6_cprod;
  logic [PRW+1:0]        s6_sum [2];
  logic                  s6_last;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en6) v6 <= v5;
    if (en6) begin
      s6_cprod  <= s5_cprod;
      s6_sum[0] <= (PRW+2)'(s5_sum[0]) + (PRW+2)'(s5_sum[1]);
      s6_sum[1] <= (PRW+2)'(s5_sum[2]) + (PRW+2)'(s5_sum[3]);
      s6_last   <= s5_last;
    end
  end

  // ---------------- stage 7: accumulate ----------------
  logic signed [AW-1:0] s7_acc;
  logic                 s7_last;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en7) v7 <= v6;
    if (en7) begin
      s7_acc  <= AW'(s6_sum[0]) + AW'(s6_sum[1]) + AW'(s6_cprod);
      s7_last <= s6_last;
    end
  end

  // ---------------- output: round half up and clamp ----------------
  logic signed [AW-1:0] rnd;
  logic [HW-1:0]        hi;
  logic [PB-1:0]        res;
  logic                 sat;

  always_comb begin
    rnd = s7_acc + AW'(HALF_Q16);
    hi  = rnd[AW-1:ROUND_SHIFT];
    if (rnd[AW-1]) begin
      res = '0;
      sat = 1'b1;
    end else if (hi[HW-1:PB] != '0) begin
      res = '1;
      sat = 1'b1;
    end else begin
      res = hi[PB-1:0];
      sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en_o) m_tvalid <= v7;
    if (en_o) begin
      m_tdata    <= OUT_W'(res);
      m_tlast    <= s7_last;
      m_tuser[0] <= sat;
    end
  end

endmodule

[rtl/ndf_wtab_ram.sv]
// Weight table memory: one write port, two registered read ports.
// No dependencies.
module ndf_wtab_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 17,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             en,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/ndf_checker.sv]
// Port-level checks for the nonlinear diffusion 3x3 filter, bound to its top level.
// Depends on nonlinear_diffusion_3x3_filter_top for the bind target.
module ndf_checker #(
  parameter int PIXEL_BITS = ndf_pkg::DEF_PIXEL_BITS,
  localparam int OUT_W = ((PIXEL_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast,
  input logic [0:0]       m_tuser
);

  // hold a stalled result beat unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

  // a clamped sum can only show as the bottom or top of the pixel range
  a_sat_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[PIXEL_BITS-1:0] == '0)
                               || (m_tdata[PIXEL_BITS-1:0] == '1))
    else $error("saturated flag with an unclamped value");

endmodule

bind nonlinear_diffusion_3x3_filter_top ndf_checker #(
  .PIXEL_BITS(PIXEL_BITS)
) u_ndf_checker (.*);

[tb/tb_nonlinear_diffusion_3x3_filter_top.sv]
// Self-checking testbench for the nonlinear diffusion 3x3 filter top level.
// Depends on ndf_pkg and the RTL; drives items, register writes and random stalls,
// and checks every result against a built-in predictor.
`timescale 1ns / 100ps

module tb_nonlinear_diffusion_3x3_filter_top;
  import ndf_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE_CYCLES = 12;
  localparam int unsigned MAX_ROW_LEN_TB = DEF_MAX_ROW_LENGTH;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
    logic        sat;
  } smooth_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  op;
    logic [15:0] pix;
    logic [7:0]  idx;
    logic [16:0] wt;
    bit          typed;
    bit          want_result;
    smooth_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = OP_DRAIN;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ROW_LENGTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  nonlinear_diffusion_3x3_filter_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  bit [16:0]   wtab [256];
  bit [15:0]   rows_mem [4][1024];
  int unsigned len_reg, rows_reg, col_cnt, row_cnt, pend_cnt;
  smooth_t     pending_q [$];

  int          errors = 0;
  int unsigned cycles = 0;
  int          rx_wait = 0;
  bit          calm = 1'b0;
  int          rand_items = 0;
  smooth_t     got;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_ROW_LEN_TB) return MAX_ROW_LEN_TB;
    return len_reg;
  endfunction

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROW_COUNT) return MAX_ROW_COUNT;
    return rows_reg;
  endfunction

  function automatic smooth_t smooth_at(input int unsigned q);
    int unsigned w, h, qr, qc, centre, p, d, ix;
    int unsigned rs [3];
    int unsigned cs [3];
    longint acc, wsum, rounded;
    smooth_t r;
    w = eff_len();
    h = eff_rows();
    qr = q / w;
    qc = q % w;
    rs[0] = (qr != 0) ? qr - 1 : 0;
    rs[1] = qr;
    rs[2] = (qr + 1 < h) ? qr + 1 : h - 1;
    cs[0] = (qc != 0) ? qc - 1 : 0;
    cs[1] = qc;
    cs[2] = (qc + 1 < w) ? qc + 1 : w - 1;
    centre = rows_mem[rs[1] & 3][cs[1]];
    acc = 0;
    wsum = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (!(i == 1 && j == 1)) begin
          p = rows_mem[rs[i] & 3][cs[j]];
          d = (p > centre) ? p - centre : centre - p;
          ix = d >> FRAC_BITS;
          wsum += wtab[ix];
          acc += longint'(wtab[ix]) * longint'(p);
        end
    acc += (longint'(ONE_Q16) - wsum) * longint'(centre);
    rounded = acc + HALF_Q16;
    r.sat = 1'b0;
    if (rounded < 0) begin
      r.value = '0;
      r.sat = 1'b1;
    end else if ((rounded >>> ROUND_SHIFT) > 65535) begin
      r.value = 16'hFFFF;
      r.sat = 1'b1;
    end else begin
      r.value = 16'(rounded >>> ROUND_SHIFT);
    end
    r.last = (q == w * h - 1);
    return r;
  endfunction

  // advance the predictor by one accepted item
  task automatic predict_item(input logic [1:0] op, input logic [15:0] pix,
                              input logic [7:0] idx, input logic [16:0] wt,
                              output bit made, output smooth_t r);
    int unsigned w, h, n;
    w = eff_len();
    h = eff_rows();
    made = 1'b0;
    r = '0;
    case (op)
      OP_LOAD: wtab[idx] = wt;
      OP_PIXEL: begin
        if (pend_cnt != 0) begin
          col_cnt = 0; row_cnt = 0; pend_cnt = 0;
        end
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        rows_mem[row_cnt & 3][col_cnt] = pix;
        n = row_cnt * w + col_cnt;
        if (n >= w + 1) begin
          r = smooth_at(n - w - 1);
          made = 1'b1;
        end
        col_cnt++;
        if (col_cnt == w) begin
          col_cnt = 0;
          row_cnt++;
          if (row_cnt == h) begin
            row_cnt = 0;
            pend_cnt = (w * h < w + 1) ? w * h : w + 1;
          end
        end
      end
      OP_DRAIN: if (pend_cnt != 0) begin
        r = smooth_at(w * h - pend_cnt);
        pend_cnt--;
        made = 1'b1;
      end
      default: ;
    endcase
    if (made) pending_q.push_back(r);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [15:0] pix,
                           input logic [7:0] idx, input logic [16:0] wt,
                           output bit made, output smooth_t r);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {7'b0, wt, idx, pix};
    do @(posedge clk); while (!s_tready);
    predict_item(op, pix, idx, wt, made, r);
  endtask

  task automatic push(input logic [1:0] op, input logic [15:0] pix,
                      input logic [7:0] idx, input logic [16:0] wt);
    bit made;
    smooth_t r;
    send_item(op, pix, idx, wt, made, r);
  endtask

  // hold off until every result is in and the pipeline has emptied
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] ix, input int unsigned v);
    settle();
    cfg_valid = 1'b1;
    cfg_index = ix;
    cfg_data = CFG_DATA_BITS'(v);
    do @(posedge clk); while (!cfg_ready);
    if (ix == REG_ROW_LENGTH) len_reg = v & 11'h7FF;
    else rows_reg = v & 13'h1FFF;
    col_cnt = 0; row_cnt = 0; pend_cnt = 0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] rand_pix(input logic [15:0] base);
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 1023)) - 16'd512;
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return base + 16'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic run_frame(input int unsigned w, input int unsigned h, input bit count_it);
    logic [15:0] base;
    int unsigned drains;
    base = 16'($urandom);
    for (int unsigned k = 0; k < w * h; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        push($urandom_range(0, 1) ? OP_SPARE : OP_LOAD, 16'($urandom),
             8'($urandom), 17'($urandom_range(0, 8192)));
      end
      push(OP_PIXEL, rand_pix(base), 8'($urandom), 17'($urandom));
      if (count_it) rand_items++;
    end
    drains = (w * h < w + 1) ? w * h : w + 1;
    // cut a drain run short now and then so the next pixel drops the rest, or add spare drains
    if (count_it && $urandom_range(0, 5) == 0) drains = $urandom_range(0, drains);
    else if ($urandom_range(0, 3) == 0) drains += $urandom_range(1, 3);
    for (int unsigned k = 0; k < drains; k++) begin
      push(OP_DRAIN, 16'($urandom), 8'($urandom), 17'($urandom));
      if (count_it) rand_items++;
    end
  endtask

  dir_row_t dir_rows [$];

  function automatic dir_row_t item_row(input logic [1:0] op, input logic [15:0] pix,
                                        input logic [7:0] idx, input logic [16:0] wt);
    dir_row_t d;
    d = '{default: '0};
    d.op = op; d.pix = pix; d.idx = idx; d.wt = wt;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] ix,
                                       input int unsigned v);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1; d.idx = 8'(ix); d.pix = 16'(v);
    return d;
  endfunction

  function automatic dir_row_t typed_row(input dir_row_t d, input bit any,
                                         input smooth_t r);
    d.typed = 1'b1; d.want_result = any; d.want = r;
    return d;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_nonlinear_diffusion_3x3_filter_top failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", m_tdata));
      end else begin
        got = pending_q.pop_front();
        if (m_tdata !== got.value)
          report($sformatf("smoothed_value %h, want %h", m_tdata, got.value));
        if (m_tlast !== got.last)
          report($sformatf("frame_last %b, want %b", m_tlast, got.last));
        if (m_tuser[0] !== got.sat)
          report($sformatf("saturated %b, want %b", m_tuser[0], got.sat));
      end
      rx_wait = draw_gap();
    end

  always @(negedge clk)
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait = rx_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end

  initial begin
    bit made;
    smooth_t r;
    dir_row_t d;
    int unsigned w, h;

    len_reg = RESET_LEN;
    rows_reg = RESET_ROWS;
    col_cnt = 0; row_cnt = 0; pend_cnt = 0;
    foreach (wtab[i]) wtab[i] = '0;
    foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole weight table so no pixel ever picks an unwritten entry
    for (int i = 0; i < 256; i++)
      push(OP_LOAD, 16'($urandom), 8'(i), 17'($urandom_range(0, 8192)));
    // reset geometry: a little over one row
    for (int i = 0; i < 260; i++) push(OP_PIXEL, 16'($urandom), 8'd0, 17'd0);

    dir_rows.push_back(typed_row(item_row(OP_DRAIN, 16'hFFFF, 8'hFF, 17'h1FFFF), 0, '0));
    dir_rows.push_back(cfg_row(REG_ROW_LENGTH, 2));
    dir_rows.push_back(typed_row(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0), 0, '0));
    dir_rows.push_back(typed_row(item_row(OP_SPARE, 16'hFFFF, 8'hFF, 17'h10000), 0, '0));
    dir_rows.push_back(item_row(OP_LOAD, 16'd0, 8'd255, 17'd65536));
    dir_rows.push_back(item_row(OP_LOAD, 16'd0, 8'd0, 17'd0));
    dir_rows.push_back(cfg_row(REG_ROW_COUNT, 1));
    dir_rows.push_back(item_row(OP_PIXEL, 16'h0000, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_PIXEL, 16'hFFFF, 8'd0, 17'd0));
    // bright neighbours at full weight overflow high, then dark ones pull below zero
    dir_rows.push_back(typed_row(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0), 1,
                                 '{value: 16'hFFFF, last: 1'b0, sat: 1'b1}));
    dir_rows.push_back(typed_row(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0), 1,
                                 '{value: 16'h0000, last: 1'b1, sat: 1'b1}));
    dir_rows.push_back(typed_row(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0), 0, '0));
    dir_rows.push_back(cfg_row(REG_ROW_COUNT, 2));
    dir_rows.push_back(item_row(OP_PIXEL, 16'h1234, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_PIXEL, 16'h1300, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_PIXEL, 16'h8000, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_PIXEL, 16'h7F80, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0));
    // pixel while results still pending starts a new frame
    dir_rows.push_back(item_row(OP_PIXEL, 16'h00FF, 8'd0, 17'd0));
    dir_rows.push_back(cfg_row(REG_ROW_LENGTH, 0));
    dir_rows.push_back(cfg_row(REG_ROW_COUNT, 0));
    dir_rows.push_back(item_row(OP_PIXEL, 16'hABCD, 8'd0, 17'd0));
    dir_rows.push_back(item_row(OP_DRAIN, 16'd0, 8'd0, 17'd0));
    dir_rows.push_back(cfg_row(REG_ROW_LENGTH, 2047));
    dir_rows.push_back(cfg_row(REG_ROW_COUNT, 8191));

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      if (d.is_cfg) begin
        write_reg(CFG_INDEX_BITS'(d.idx), d.pix);
      end else begin
        send_item(d.op, d.pix, d.idx, d.wt, made, r);
        if (d.typed && (made != d.want_result || (made && r != d.want)))
          report($sformatf("directed row %0d: predicted %b/%h", i, made, r));
      end
    end
    // widest row: run past the last column into the second row
    for (int i = 0; i < 1030; i++) push(OP_PIXEL, rand_pix(16'h4000), 8'd0, 17'd0);
    push(OP_DRAIN, 16'd0, 8'd0, 17'd0);

    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) w = $urandom_range(1, 40);
      else w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      write_reg(REG_ROW_LENGTH, w);
      write_reg(REG_ROW_COUNT, h);
      calm = ($urandom_range(0, 3) == 0);
      // mostly new weights of at most one eighth, sometimes a heavy entry up to one
      for (int i = $urandom_range(0, 3); i > 0; i--)
        push(OP_LOAD, 16'($urandom), 8'($urandom),
             $urandom_range(0, 7) == 0 ? 17'($urandom_range(0, 65536))
                                       : 17'($urandom_range(0, 8192)));
      run_frame(w, h, 1'b1);
      if ($urandom_range(0, 9) == 0) settle();
    end
    calm = 1'b0;

    settle();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("tb_nonlinear_diffusion_3x3_filter_top passed");
    else $display("tb_nonlinear_diffusion_3x3_filter_top failed");
    $finish;
  end

endmodule

[files.f]
rtl/ndf_pkg.sv
rtl/ndf_wtab_ram.sv
rtl/nonlinear_diffusion_3x3_filter_top.sv
rtl/ndf_checker.sv
tb/tb_nonlinear_diffusion_3x3_filter_top.sv
